[rtl/tsci_pkg.sv]
`timescale 1ns / 1ps

package tsci_pkg;

	// Default curve resolution: entries between v = -1 and v = +1
	localparam int TABLE_SIZE_DEF = 1024;

	// Fraction bits of the table position
	localparam int FRAC_BITS = 27;

	// Curve entries are Q2.15 values in [-32768, 32768]
	localparam int ENTRY_W = 17;

	typedef logic signed [15:0]        sample_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;

	// Constant-time helpers for building the curve at elaboration
	localparam longint unsigned ONE_Q31 = 64'd2147483648;
	localparam int DIV_BITS = 48;
	localparam int EXP_TERMS = 20;
	localparam int EXP_SCALE = 20;

	// Restoring division, one quotient bit per iteration (elaboration only)
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		int i;
		rem = 64'd0;
		quo = 64'd0;
		for (i = DIV_BITS - 1; i >= 0; i--) begin
			rem = (rem << 1) | ((num >> i) & 64'd1);
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// exp(-p/half) in Q0.31 for 0 <= p <= half, alternating series
	function automatic longint unsigned exp_neg_frac(input longint unsigned p,
		input longint unsigned half);
		longint unsigned term;
		longint sum;
		longint unsigned k;
		term = ONE_Q31;
		sum = longint'(ONE_Q31);
		for (k = 64'd1; k <= 64'(EXP_TERMS); k++) begin
			term = udiv(term * p, half * k);
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q31))
			sum = longint'(ONE_Q31);
		return 64'(sum);
	endfunction

	// One entry of tanh(10*v): (1-q)/(1+q) with q = exp(-2|x|), rounded to Q2.15
	function automatic entry_t curve_entry(input int idx, input int half,
		input longint unsigned e1);
		int d;
		longint unsigned ad;
		longint unsigned y;
		longint unsigned q;
		longint unsigned num;
		longint unsigned den;
		longint unsigned mag;
		int n;
		int k;
		entry_t m;
		d = idx - half;
		ad = (d < 0) ? 64'(-d) : 64'(d);
		y = 64'(EXP_SCALE) * ad;
		n = 0;
		while (y >= 64'(half)) begin
			y = y - 64'(half);
			n = n + 1;
		end
		q = exp_neg_frac(y, 64'(half));
		for (k = 0; k < n; k++)
			q = (q * e1 + (64'd1 << 30)) >> 31;
		if (q > ONE_Q31)
			q = ONE_Q31;
		num = (ONE_Q31 - q) << 16;
		den = ONE_Q31 + q;
		mag = udiv(num + den, den << 1);
		m = ENTRY_W'(mag);
		return (d < 0) ? -m : m;
	endfunction

endpackage

[rtl/tsci_in_if.sv]
`timescale 1ns / 1ps

interface tsci_in_if;
	import tsci_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;
	sample_t drive_gain;
	sample_t limit_gain;
	logic    end_of_block;

	modport source (output valid, output sample_in, output drive_gain,
		output limit_gain, output end_of_block, input ready);
	modport sink (input valid, input sample_in, input drive_gain,
		input limit_gain, input end_of_block, output ready);
endinterface

[rtl/tsci_out_if.sv]
`timescale 1ns / 1ps

interface tsci_out_if;
	import tsci_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    end_of_block_out;

	modport source (output valid, output sample_out, output end_of_block_out,
		input ready);
	modport sink (input valid, input sample_out, input end_of_block_out,
		output ready);
endinterface

[rtl/tanh_soft_clip_interp.sv]
`timescale 1ns / 1ps

// Tanh soft clipper with table interpolation, one audio sample per item.
// in_ch carries sample_in (Q1.15), drive_gain (Q4.12), limit_gain (Q1.15)
// and end_of_block; out_ch returns sample_out (Q1.15, saturated) and a copy
// of end_of_block. Both are valid/ready channels; an item moves on a rising
// edge with valid and ready high.
// out_ch.valid rises once an accepted item reaches the last stage; it leaves
// on an edge with out_ch.ready high. Throughput is one item per cycle while
// out_ch.ready stays high: the datapath is seven register stages (drive
// multiply, position scale, registered dual-read curve ROM, difference,
// interpolation multiply-add, split limit multiply, round and saturate).
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills the empty stages first; in_ch.ready drops only once all
// seven stages hold an item. Nothing is dropped or repeated.
// The curve ROM is a constant, built at elaboration from TABLE_SIZE.
// Reset (arst_n low) clears the stage valid bits; the ROM needs no fill
// and items are taken from the first cycle after reset.
module tanh_soft_clip_interp #(
	parameter int TABLE_SIZE = tsci_pkg::TABLE_SIZE_DEF
) (
	input logic     clk,
	input logic     arst_n,
	tsci_in_if.sink   in_ch,
	tsci_out_if.source out_ch
);
	import tsci_pkg::*;

	localparam int HALF  = TABLE_SIZE / 2;
	localparam int HW    = $clog2(HALF + 1) + 1;
	localparam int POS_W = 31 + HW;
	localparam int IW    = POS_W - FRAC_BITS;
	localparam int AW    = $clog2(TABLE_SIZE + 1);
	localparam int NS    = 7;
	localparam int ACC_W = ENTRY_W + FRAC_BITS;
	localparam int SPLIT = 22;
	localparam int SUM_W = 60;
	localparam int OUT_SHIFT = 42;

	localparam logic signed [HW-1:0]    HALF_C  = HW'(HALF);
	localparam logic signed [POS_W-1:0] POS_OFS = POS_W'(HALF) << FRAC_BITS;
	localparam logic [IW-1:0]           TOP_IDX = IW'(TABLE_SIZE);
	localparam logic [AW-1:0]           TOP_ADDR = AW'(TABLE_SIZE);
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (OUT_SHIFT - 1);
	localparam logic signed [17:0]      SAT_MAX = 18'sd32767;
	localparam logic signed [17:0]      SAT_MIN = -18'sd32768;

	typedef entry_t curve_t [TABLE_SIZE+1];

	// Fill the constant curve, one entry per table position
	function automatic curve_t build_curve();
		curve_t c;
		longint unsigned e1;
		int i;
		e1 = exp_neg_frac(64'(HALF), 64'(HALF));
		for (i = 0; i <= TABLE_SIZE; i++)
			c[i] = curve_entry(i, HALF, e1);
		return c;
	endfunction

	localparam curve_t CURVE = build_curve();

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	logic signed [31:0]          sg_s1;
	sample_t                     lim_s1, lim_s2, lim_s3, lim_s4, lim_s5;
	logic [NS-1:0]               eob_p;
	logic signed [POS_W-1:0]     pos_s2;
	entry_t                      a_s3, b_s3, a_s4;
	logic [FRAC_BITS-1:0]        f_s3, f_s4;
	logic signed [ENTRY_W:0]     diff_s4;
	logic signed [ACC_W-1:0]     acc_s5;
	logic signed [ACC_W-SPLIT+15:0] phi_s6;
	logic signed [SPLIT+16:0]    plo_s6;
	sample_t                     sample_s7;

	logic signed [POS_W-1:0] pos_w;
	logic                    below_w, above_w;
	logic [IW-1:0]           idx_w;
	logic [AW-1:0]           addr_a_w, addr_b_w;
	logic [FRAC_BITS-1:0]    f_w;
	logic signed [SUM_W-1:0] sum_w;
	logic signed [17:0]      rnd_w;
	sample_t                 sat_w;

	// Advance a stage when it is empty or the next one moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ch.ready;
		for (int k = NS - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign in_ch.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_ch.valid;
			for (int k = 1; k < NS; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Carry the block marker alongside the data
	always_ff @(posedge clk) begin
		if (en[0])
			eob_p[0] <= in_ch.end_of_block;
		for (int k = 1; k < NS; k++)
			if (en[k])
				eob_p[k] <= eob_p[k-1];
	end

	// Stage 1: drive multiply
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sg_s1  <= in_ch.sample_in * in_ch.drive_gain;
			lim_s1 <= in_ch.limit_gain;
		end
	end

	// Stage 2: table position in Q.27
	assign pos_w = sg_s1 * HALF_C + POS_OFS;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_s2 <= pos_w;
			lim_s2 <= lim_s1;
		end
	end

	// Stage 3: clamp the position and read both neighbors from the ROM
	always_comb begin
		below_w = pos_s2[POS_W-1];
		idx_w   = pos_s2[POS_W-1:FRAC_BITS];
		above_w = !below_w && (idx_w >= TOP_IDX);
		if (below_w) begin
			addr_a_w = '0;
			addr_b_w = '0;
			f_w      = '0;
		end else if (above_w) begin
			addr_a_w = TOP_ADDR;
			addr_b_w = TOP_ADDR;
			f_w      = '0;
		end else begin
			addr_a_w = idx_w[AW-1:0];
			addr_b_w = idx_w[AW-1:0] + AW'(1);
			f_w      = pos_s2[FRAC_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a_s3   <= CURVE[addr_a_w];
			b_s3   <= CURVE[addr_b_w];
			f_s3   <= f_w;
			lim_s3 <= lim_s2;
		end
	end

	// Stage 4: slope between neighbors
	always_ff @(posedge clk) begin
		if (en[3]) begin
			diff_s4 <= b_s3 - a_s3;
			a_s4    <= a_s3;
			f_s4    <= f_s3;
			lim_s4  <= lim_s3;
		end
	end

	// Stage 5: interpolate in Q.42
	always_ff @(posedge clk) begin
		if (en[4]) begin
			acc_s5 <= (ACC_W'(a_s4) <<< FRAC_BITS) + ($signed({1'b0, f_s4}) * diff_s4);
			lim_s5 <= lim_s4;
		end
	end

	// Stage 6: limit gain as two partial products
	always_ff @(posedge clk) begin
		if (en[5]) begin
			phi_s6 <= $signed(acc_s5[ACC_W-1:SPLIT]) * lim_s5;
			plo_s6 <= $signed({1'b0, acc_s5[SPLIT-1:0]}) * lim_s5;
		end
	end

	// Stage 7: combine, round half up and saturate
	always_comb begin
		sum_w = (SUM_W'(phi_s6) <<< SPLIT) + SUM_W'(plo_s6) + RND;
		rnd_w = sum_w[OUT_SHIFT+17:OUT_SHIFT];
		if (rnd_w > SAT_MAX)
			sat_w = SAT_MAX[15:0];
		else if (rnd_w < SAT_MIN)
			sat_w = SAT_MIN[15:0];
		else
			sat_w = rnd_w[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[6])
			sample_s7 <= sat_w;
	end

	assign out_ch.valid            = vld_q[NS-1];
	assign out_ch.sample_out       = sample_s7;
	assign out_ch.end_of_block_out = eob_p[NS-1];

`ifndef ASSERT_OFF
	// An accepted item occupies the first stage on the next edge
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[0])
		else $error("accepted item missing from stage 1");

	// Input stalls only when every stage is full and the receiver holds
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (&vld_q) && !out_ch.ready)
		else $error("input stalled with room in the pipeline");

	// A held ROM stage keeps its item and its read data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] && !en[2] |=> vld_q[2] && $stable(a_s3) && $stable(b_s3))
		else $error("stalled ROM stage changed");
`endif

endmodule
